@@ rtl/lfat_pkg.sv @@
// Shared types and constants for the LRU fully associative tag store.
package lfat_pkg;

   localparam int NUM_LINES_DEF = 8;
   localparam int KEY_W         = 64;
   localparam int VALUE_W       = 32;
   localparam int SLOT_W        = 3;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_STORE  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  store_value;
   } req_item_type;

   typedef struct packed {
      logic                hit;
      logic [VALUE_W-1:0]  read_value;
      logic [SLOT_W-1:0]   slot;
   } rsp_item_type;

   // one line of the tag/value memory
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } line_data_type;

endpackage

@@ rtl/lfat_tag_mem.sv @@
// Tag/value memory with per-line valid bits and a registered read port.
module lfat_tag_mem #(
   parameter int NUM_LINES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [$clog2(NUM_LINES)-1:0] wr_addr,
   input  lfat_pkg::line_data_type     wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(NUM_LINES)-1:0] rd_addr,
   output lfat_pkg::line_data_type     rd_data,
   output logic                        rd_valid
);
   import lfat_pkg::*;

   line_data_type              mem [NUM_LINES];
   logic [NUM_LINES-1:0]       valid_ff;
   line_data_type              rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ rtl/lfat_order_mem.sv @@
// Recency order memory: position -> line, unwritten positions read as their own index.
module lfat_order_mem #(
   parameter int NUM_LINES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_LINES)-1:0] wr_addr,
   input  logic [$clog2(NUM_LINES)-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_LINES)-1:0] rd_addr,
   output logic [$clog2(NUM_LINES)-1:0] rd_data
);
   localparam int IDX_W = $clog2(NUM_LINES);

   logic [IDX_W-1:0]     mem [NUM_LINES];
   logic [NUM_LINES-1:0] written_ff;
   logic [IDX_W-1:0]     rd_q_ff;
   logic [IDX_W-1:0]     rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff    <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // reset order is identity: a never-written position holds its own index
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = written_ff[rd_addr_ff] ? rd_q_ff : rd_addr_ff;

endmodule

@@ rtl/lru_fully_assoc_tag_store_unit.sv @@
// Single-set fully associative cache with move-to-front LRU replacement.
// Store: victim read, tag write, then order walk, from accept to result valid.
// Lookup: tag scan, one line per cycle through the tag memory read port,
// then on a hit a walk through the order memory that moves the line to the front.
// Throughput: one item at a time; next item accepted once the result is registered.
// Reset: valid bits cleared, order reads as identity; tags and values stay unwritten.
module lru_fully_assoc_tag_store_unit #(
   parameter int NUM_LINES = lfat_pkg::NUM_LINES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lfat_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lfat_pkg::rsp_item_type rsp_item
);
   import lfat_pkg::*;

   localparam int IDX_W = $clog2(NUM_LINES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_LINES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_LINES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VICT_RD,   // read least recent position
      ST_VICT_WR,   // write tag/value into victim line
      ST_SCAN,      // tag compare, one line per cycle
      ST_WALK,      // move-to-front through the order memory
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   req_item_type          req_ff, req_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;       // next address to read
   logic                  pend_ff, pend_in;     // read issued last cycle
   logic [IDX_W-1:0]      pos_ff, pos_in;       // address of that read
   logic [IDX_W-1:0]      line_ff, line_in;     // line moving to front
   logic [IDX_W-1:0]      carry_ff, carry_in;   // entry shifted down one position
   logic                  hit_ff, hit_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   // memory ports
   logic                  tag_wr_en;
   logic [IDX_W-1:0]      tag_wr_addr;
   line_data_type         tag_wr_data;
   logic                  tag_rd_en;
   line_data_type         tag_rd_data;
   logic                  tag_rd_valid;
   logic                  ord_wr_en;
   logic [IDX_W-1:0]      ord_wr_addr;
   logic [IDX_W-1:0]      ord_wr_data;
   logic                  ord_rd_en;
   logic [IDX_W-1:0]      ord_rd_addr;
   logic [IDX_W-1:0]      ord_rd_data;

   logic                  issue;
   logic [SLOT_W+IDX_W-1:0] slot_ext;

   lfat_tag_mem #(.NUM_LINES(NUM_LINES)) u_tag_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tag_wr_en),
      .wr_addr  (tag_wr_addr),
      .wr_data  (tag_wr_data),
      .rd_en    (tag_rd_en),
      .rd_addr  (cnt_ff[IDX_W-1:0]),
      .rd_data  (tag_rd_data),
      .rd_valid (tag_rd_valid)
   );

   lfat_order_mem #(.NUM_LINES(NUM_LINES)) u_order_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   // slot is the line index, zero-extended or cut to the field width
   assign slot_ext = {{SLOT_W{1'b0}}, line_ff};
   assign issue    = (cnt_ff != CNT_END);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pos_in       = pos_ff;
      line_in      = line_ff;
      carry_in     = carry_ff;
      hit_in       = hit_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      tag_wr_en    = 1'b0;
      tag_wr_addr  = ord_rd_data;
      tag_wr_data  = '{key: req_ff.key, value: req_ff.store_value};
      tag_rd_en    = 1'b0;
      ord_wr_en    = 1'b0;
      ord_wr_addr  = pos_ff;
      ord_wr_data  = carry_ff;
      ord_rd_en    = 1'b0;
      ord_rd_addr  = cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_item;
               cnt_in  = '0;
               pend_in = 1'b0;
               state_in = (req_item.req_type == REQ_STORE) ? ST_VICT_RD : ST_SCAN;
            end
         end
         ST_VICT_RD: begin
            ord_rd_en   = 1'b1;
            ord_rd_addr = LAST_POS;
            state_in    = ST_VICT_WR;
         end
         ST_VICT_WR: begin
            tag_wr_en = 1'b1;
            line_in   = ord_rd_data;
            carry_in  = ord_rd_data;
            hit_in    = 1'b1;
            value_in  = req_ff.store_value;
            cnt_in    = '0;
            pend_in   = 1'b0;
            state_in  = ST_WALK;
         end
         ST_SCAN: begin
            tag_rd_en = issue;
            pend_in   = issue;
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
               pos_in = cnt_ff[IDX_W-1:0];
            end
            // first valid match in ascending line order wins
            if (pend_ff && tag_rd_valid && (tag_rd_data.key == req_ff.key)) begin
               hit_in   = 1'b1;
               line_in  = pos_ff;
               carry_in = pos_ff;
               value_in = tag_rd_data.value;
               cnt_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_WALK;
            end else if (!pend_ff && !issue) begin
               hit_in   = 1'b0;
               line_in  = '0;
               value_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            // each position takes the previous one's entry until the line itself is met
            ord_rd_en = issue;
            pend_in   = issue;
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
               pos_in = cnt_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               ord_wr_en = 1'b1;
               carry_in  = ord_rd_data;
               if ((ord_rd_data == line_ff) || (pos_ff == LAST_POS)) begin
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{hit: hit_ff, read_value: value_ff,
                                slot: slot_ext[SLOT_W-1:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         req_ff       <= req_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         carry_ff     <= carry_in;
         hit_ff       <= hit_in;
         value_ff     <= value_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.hit |-> (rsp_item.read_value == '0) && (rsp_item.slot == '0))
      else $error("miss result carries nonzero value or slot");

   a_walk_wr_follows_rd: assert property (@(posedge clock) disable iff (reset)
      ord_wr_en |-> $past(ord_rd_en) && (ord_wr_addr == $past(ord_rd_addr)))
      else $error("order write not at position read the cycle before");

   a_victim_to_walk: assert property (@(posedge clock) disable iff (reset)
      tag_wr_en |=> (state_ff == ST_WALK) && (carry_ff == $past(tag_wr_addr)))
      else $error("victim line not carried into order walk");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in flight");
`endif

endmodule
